// ===== sv/pdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// pdlp_pkg: shared constants and a helper for the peak decimator pyramid
// Holds the parameter defaults, the peak scaling constants and the byte
// conversion used for level-0 entries.
// ----------------------------------------------------------------------------
package pdlp_pkg;

   localparam int WINDOW_DEF      = 16;
   localparam int LEVELS_DEF      = 4;
   localparam int ENTRIES_DEF     = 4096;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int SAMPLE_W   = 16;
   localparam int PEAK_W     = 8;
   localparam int PEAK_SHIFT = 7;
   localparam int PEAK_MAX   = 255;

   // Scales a 17-bit magnitude down by 128 and saturates it to a byte.
   function automatic logic [PEAK_W-1:0] peak_byte(input logic [SAMPLE_W:0] mag);
      logic [SAMPLE_W-PEAK_SHIFT:0] v;
      v = (SAMPLE_W-PEAK_SHIFT+1)'(mag >> PEAK_SHIFT);
      return (v > (SAMPLE_W-PEAK_SHIFT+1)'(PEAK_MAX)) ? PEAK_W'(PEAK_MAX) : v[PEAK_W-1:0];
   endfunction

endpackage

// ===== sv/pdlp_front.sv =====
// ----------------------------------------------------------------------------
// pdlp_front: window tracker
// Takes in samples, keeps the running maximum and minimum of the open window
// and pushes one level-0 entry into the queue when the window closes.
// ----------------------------------------------------------------------------
module pdlp_front #(
   parameter int WINDOW  = pdlp_pkg::WINDOW_DEF,
   parameter int ENTRIES = pdlp_pkg::ENTRIES_DEF,
   parameter int IDX_W   = $clog2(ENTRIES),
   parameter int ENT_W   = 1 + IDX_W + 2*pdlp_pkg::PEAK_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pdlp_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [ENT_W-1:0]              q_data
);

   localparam int CNT_W = $clog2(WINDOW);

   logic [CNT_W-1:0]                    cnt_ff, cnt_in, cnt_base;
   logic signed [pdlp_pkg::SAMPLE_W-1:0] high_ff, high_in, high_base, new_high;
   logic signed [pdlp_pkg::SAMPLE_W-1:0] low_ff, low_in, low_base, new_low;
   logic signed [pdlp_pkg::SAMPLE_W-1:0] sample;
   logic [IDX_W-1:0]                    base_ff, base_in, base_v;
   logic                                clr_ff, clr_in;
   logic                                accept, closing;
   logic [pdlp_pkg::SAMPLE_W:0]         high_mag, low_mag;
   logic [pdlp_pkg::PEAK_W-1:0]         hi_byte, lo_byte;

   // Only a sample that would close the window needs room in the queue.
   assign req_tready = !((cnt_ff == CNT_W'(WINDOW-1)) && q_full);

   always_comb begin
      accept    = req_tvalid && req_tready;
      sample    = signed'(req_tdata);
      cnt_base  = req_tuser ? '0 : cnt_ff;
      high_base = req_tuser ? '0 : high_ff;
      low_base  = req_tuser ? '0 : low_ff;
      base_v    = req_tuser ? '0 : base_ff;
      new_high  = (sample > high_base) ? sample : high_base;
      new_low   = (sample < low_base) ? sample : low_base;
      closing   = (cnt_base == CNT_W'(WINDOW-1));
      high_mag  = {1'b0, new_high};
      low_mag   = (pdlp_pkg::SAMPLE_W+1)'(0) - {new_low[pdlp_pkg::SAMPLE_W-1], new_low};
      hi_byte   = pdlp_pkg::peak_byte(high_mag);
      lo_byte   = pdlp_pkg::peak_byte(low_mag);
      q_push    = accept && closing;
      q_data    = {req_tuser | clr_ff, base_v, hi_byte, lo_byte};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      high_in = high_ff;
      low_in  = low_ff;
      base_in = base_ff;
      clr_in  = clr_ff;
      if (accept) begin
         if (closing) begin
            cnt_in  = '0;
            high_in = '0;
            low_in  = '0;
            base_in = (base_v == IDX_W'(ENTRIES-1)) ? '0 : base_v + IDX_W'(1);
            clr_in  = 1'b0;
         end else begin
            cnt_in  = cnt_base + CNT_W'(1);
            high_in = new_high;
            low_in  = new_low;
            base_in = base_v;
            clr_in  = clr_ff | req_tuser;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         high_ff <= '0;
         low_ff  <= '0;
         base_ff <= '0;
         clr_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         base_ff <= base_in;
         clr_ff  <= clr_in;
      end
   end

endmodule

// ===== sv/pdlp_queue.sv =====
// ----------------------------------------------------------------------------
// pdlp_queue: short entry queue
// A small register FIFO that parts the window tracker from the pyramid.
// ----------------------------------------------------------------------------
module pdlp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pdlp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("entry queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("entry queue read while empty");

endmodule

// ===== sv/pdlp_back.sv =====
// ----------------------------------------------------------------------------
// pdlp_back: pyramid builder
// Walks each level-0 entry up the levels, pairing it with each level's held
// entry, and drives the result register at one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module pdlp_back #(
   parameter int LEVELS = pdlp_pkg::LEVELS_DEF,
   parameter int IDX_W  = 12,
   parameter int LVL_W  = 2,
   parameter int ENT_W  = 1 + IDX_W + 2*pdlp_pkg::PEAK_W,
   parameter int RSP_W  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  logic [ENT_W-1:0] q_data,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int PW = pdlp_pkg::PEAK_W;

   logic              busy_ff, busy_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [PW-1:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LEVELS-1:0] pend_ff, pend_in, pend_eff;
   logic [PW-1:0]     held_hi_ff [LEVELS];
   logic [PW-1:0]     held_lo_ff [LEVELS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]  rsp_level_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [PW-1:0]     rsp_hi_ff, rsp_lo_ff;
   logic              rsp_last_ff;

   logic              head_clr, cur_valid, step, top_lvl, last;
   logic [IDX_W-1:0]  head_idx, cur_idx, out_idx;
   logic [PW-1:0]     head_hi, head_lo, cur_hi, cur_lo, held_hi, held_lo;
   logic [PW-1:0]     merge_hi, merge_lo;
   logic [LVL_W-1:0]  cur_lvl;

   always_comb begin
      head_clr  = q_data[ENT_W-1];
      head_idx  = q_data[ENT_W-2 -: IDX_W];
      head_hi   = q_data[2*PW-1:PW];
      head_lo   = q_data[PW-1:0];
      // A fresh entry comes straight from the queue head; upper levels of the
      // same entry come from the working registers.
      cur_valid = busy_ff || q_valid;
      cur_lvl   = busy_ff ? lvl_ff : '0;
      cur_idx   = busy_ff ? idx_ff : head_idx;
      cur_hi    = busy_ff ? hi_ff : head_hi;
      cur_lo    = busy_ff ? lo_ff : head_lo;
      pend_eff  = (!busy_ff && head_clr) ? '0 : pend_ff;
      held_hi   = held_hi_ff[cur_lvl];
      held_lo   = held_lo_ff[cur_lvl];
      merge_hi  = (held_hi > cur_hi) ? held_hi : cur_hi;
      merge_lo  = (held_lo > cur_lo) ? held_lo : cur_lo;
      top_lvl   = (cur_lvl == LVL_W'(LEVELS-1));
      last      = top_lvl || !pend_eff[cur_lvl];
      out_idx   = cur_idx >> cur_lvl;
      step      = cur_valid && (!rsp_valid_ff || rsp_tready);
      q_pop     = step && !busy_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      lvl_in  = lvl_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      idx_in  = idx_ff;
      pend_in = pend_ff;
      if (step) begin
         pend_in = pend_eff;
         busy_in = !last;
         if (!top_lvl) begin
            pend_in[cur_lvl] = !pend_eff[cur_lvl];
         end
         lvl_in = cur_lvl + LVL_W'(1);
         hi_in  = merge_hi;
         lo_in  = merge_lo;
         idx_in = cur_idx;
      end
      rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      idx_ff <= idx_in;
      if (step && !top_lvl && !pend_eff[cur_lvl]) begin
         held_hi_ff[cur_lvl] <= cur_hi;
         held_lo_ff[cur_lvl] <= cur_lo;
      end
      if (step) begin
         rsp_level_ff <= cur_lvl;
         rsp_idx_ff   <= out_idx;
         rsp_hi_ff    <= cur_hi;
         rsp_lo_ff    <= cur_lo;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_lo_ff, rsp_hi_ff, rsp_idx_ff, rsp_level_ff});
   assign rsp_tlast  = rsp_last_ff;

   a_busy_upper: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lvl_ff != '0))
      else $error("working registers hold a level-0 entry");

   a_climb: assert property (@(posedge clock) disable iff (reset)
      (step && !last) |=> (busy_ff && (lvl_ff == LVL_W'($past(cur_lvl) + 1'b1))))
      else $error("pyramid walk did not move up one level");

   a_done: assert property (@(posedge clock) disable iff (reset)
      (step && last) |=> (!busy_ff && rsp_tvalid && rsp_tlast))
      else $error("run did not end with its last word");

endmodule

// ===== sv/peak_decimator_lod_pyramid_top.sv =====
// ----------------------------------------------------------------------------
// peak_decimator_lod_pyramid_top: min/max peak decimator with LOD pyramid
// Decimates a stream of signed 16-bit samples into peak entries per window
// and builds coarser levels by pairing entries level by level.
// ----------------------------------------------------------------------------
// The level-0 word passes through the entry queue and the result register after the
// sample that closes its window is accepted; the word of each higher level follows
// the one below it, while the builder is idle and the result side does not stall.
// Throughput: one sample per cycle; the builder emits one word per cycle unless the
// result side stalls; samples stall only if the queue is full as a window closes.
// Reset: synchronous, active high, clears control state; samples taken right after.
module peak_decimator_lod_pyramid_top #(
   parameter int WINDOW      = pdlp_pkg::WINDOW_DEF,
   parameter int LEVELS      = pdlp_pkg::LEVELS_DEF,
   parameter int ENTRIES     = pdlp_pkg::ENTRIES_DEF,
   parameter int QUEUE_DEPTH = pdlp_pkg::QUEUE_DEPTH_DEF,
   parameter int IDX_W       = $clog2(ENTRIES),
   parameter int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1,
   parameter int RSP_W       = ((LVL_W + IDX_W + 2*pdlp_pkg::PEAK_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Sample side.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pdlp_pkg::SAMPLE_W-1:0] req_tdata,  // sample
   input  logic                          req_tuser,  // block_start
   // Result side.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // level, entry_index,
                                                     // high_peak, low_peak, zero pad
   output logic                          rsp_tlast   // last_of_run
);

   // Queue word: clear-before flag, entry index, high peak, low peak.
   localparam int ENT_W = 1 + IDX_W + 2*pdlp_pkg::PEAK_W;

   logic             q_push, q_pop, q_full, q_valid;
   logic [ENT_W-1:0] q_wr_data, q_rd_data;

   // The window tracker folds samples into the running extremes. A block
   // start that arrives mid-window drops the partial window and marks the
   // next entry so the pyramid forgets its half-formed pairs first.
   pdlp_front #(
      .WINDOW (WINDOW),
      .ENTRIES(ENTRIES),
      .IDX_W  (IDX_W),
      .ENT_W  (ENT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   // The queue holds entries while the pyramid emits the words a window close
   // causes, so the sample side keeps streaming while the pyramid walks its levels.
   pdlp_queue #(
      .WIDTH(ENT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_data  (q_wr_data),
      .pop      (q_pop),
      .rd_data  (q_rd_data),
      .full     (q_full),
      .not_empty(q_valid)
   );

   // The pyramid builder emits the level-0 word, then one word for each
   // level whose pair completes, with the last one flagged.
   pdlp_back #(
      .LEVELS(LEVELS),
      .IDX_W (IDX_W),
      .LVL_W (LVL_W),
      .ENT_W (ENT_W),
      .RSP_W (RSP_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
